// ----- hdl/fsu_pkg.sv -----
// fsu_pkg: constants, types and helpers shared by the stencil update core
// no dependencies
`timescale 1ns / 1ps

package fsu_pkg;

   localparam int GRID_X = 16;
   localparam int GRID_Y = 16;
   localparam int GRID_Z = 16;
   localparam int PAD_X  = GRID_X + 2;
   localparam int PAD_Y  = GRID_Y + 2;
   localparam int PAD_Z  = GRID_Z + 2;
   localparam int PLANE  = PAD_X * PAD_Y;
   localparam int X_W    = $clog2(PAD_X);
   localparam int Y_W    = $clog2(PAD_Y);
   localparam int Z_W    = $clog2(PAD_Z);

   localparam int QUEUE_DEPTH = 4;
   localparam int Q_W         = $clog2(QUEUE_DEPTH);
   // history depth: two planes plus slack for items queued ahead of the back end
   localparam int MEM_DEPTH   = 2 * PLANE + QUEUE_DEPTH + 2;
   localparam int ADDR_W      = $clog2(MEM_DEPTH);

   localparam int DATA_W = 32;
   localparam int K_W    = 31;
   localparam int ACC_W  = 53;
   localparam int MAG_W  = 52;
   localparam int R_W    = 51;
   localparam int LO_W   = 63;
   localparam int HI_W   = 51;
   localparam logic [R_W-1:0] CLAMP_MAG = R_W'(1) << 50;

   localparam logic [K_W-1:0] HALF_DT_RESET = K_W'(32768);
   localparam logic [K_W-1:0] INV_RESET     = K_W'(65536);

   localparam logic [1:0] CSR_HALF_DT = 2'd0;
   localparam logic [1:0] CSR_INV_DX  = 2'd1;
   localparam logic [1:0] CSR_INV_DY  = 2'd2;
   localparam logic [1:0] CSR_INV_DZ  = 2'd3;

   // neighbour slots read from history
   localparam logic [2:0] NB_CENTER = 3'd0;
   localparam logic [2:0] NB_XP     = 3'd1;
   localparam logic [2:0] NB_XM     = 3'd2;
   localparam logic [2:0] NB_YP     = 3'd3;
   localparam logic [2:0] NB_YM     = 3'd4;
   localparam logic [2:0] NB_ZM     = 3'd5;
   localparam logic [2:0] NB_COUNT  = 3'd6;

   // multiply steps
   localparam logic [2:0] OP_DIV_X = 3'd0;
   localparam logic [2:0] OP_DIV_Y = 3'd1;
   localparam logic [2:0] OP_DIV_Z = 3'd2;
   localparam logic [2:0] OP_DEN   = 3'd3;
   localparam logic [2:0] OP_MX    = 3'd4;
   localparam logic [2:0] OP_MY    = 3'd5;
   localparam logic [2:0] OP_MZ    = 3'd6;

   typedef struct packed {
      logic [DATA_W-1:0] density;
      logic [DATA_W-1:0] mom_x;
      logic [DATA_W-1:0] mom_y;
      logic [DATA_W-1:0] mom_z;
      logic [DATA_W-1:0] pressure;
   } fsu_cell_type;

   localparam int CELL_W = $bits(fsu_cell_type);

   typedef struct packed {
      logic [DATA_W-1:0] mom_z;
      logic [DATA_W-1:0] pressure;
      logic [ADDR_W-1:0] addr;
      logic              emit;
      logic              last;
   } fsu_entry_type;

   typedef struct packed {
      logic [K_W-1:0] half_dt;
      logic [K_W-1:0] inv_dx;
      logic [K_W-1:0] inv_dy;
      logic [K_W-1:0] inv_dz;
   } fsu_cfg_type;

   typedef struct packed {
      logic [DATA_W-1:0] new_density;
      logic [DATA_W-1:0] new_mom_x;
      logic [DATA_W-1:0] new_mom_y;
      logic [DATA_W-1:0] new_mom_z;
      logic              last_cell;
   } fsu_result_type;

   typedef enum logic [2:0] {
      B_IDLE, B_READ, B_SET, B_LO, B_HI, B_FIN, B_ACC, B_OUT
   } fsu_back_state_type;

   // distance back in history of each neighbour slot
   function automatic logic [ADDR_W:0] nb_age(input logic [2:0] slot);
      logic [ADDR_W:0] age;
      case (slot)
         NB_CENTER: age = (ADDR_W+1)'(PLANE);
         NB_XP:     age = (ADDR_W+1)'(PLANE - 1);
         NB_XM:     age = (ADDR_W+1)'(PLANE + 1);
         NB_YP:     age = (ADDR_W+1)'(PLANE - PAD_X);
         NB_YM:     age = (ADDR_W+1)'(PLANE + PAD_X);
         default:   age = (ADDR_W+1)'(2 * PLANE);
      endcase
      return age;
   endfunction

endpackage

// ----- hdl/fluid_stencil_update_core.sv -----
// fluid_stencil_update_core: top level, register file and front/back wiring
// depends on fsu_pkg, fsu_ram, fsu_front, fsu_back
`timescale 1ns / 1ps

// Cells of the ghost-padded grid stream in raster order, x fastest. Every cell
// is written to a two-plane history ram as it is accepted; a cell that
// completes an interior cell one plane behind it yields one result, others
// none. A ghost cell is dropped by the back end as it is popped. An interior
// update in the back end runs from the pop through six registered reads of
// the history ram, then seven rounded multiplies (each a 32x31 low half and a
// 20x31 high half in turn), and ends when the result register is loaded,
// which waits until that register is empty. A four-entry queue lets the front
// keep accepting while the back works; once four items wait, full holds the
// input. A result register holds the finished item until it is popped. No
// clearing pass is needed after reset.
module fluid_stencil_update_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_density,
   input  logic [31:0] req_mom_x,
   input  logic [31:0] req_mom_y,
   input  logic [31:0] req_mom_z,
   input  logic [31:0] req_pressure,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_new_density,
   output logic [31:0] rsp_new_mom_x,
   output logic [31:0] rsp_new_mom_y,
   output logic [31:0] rsp_new_mom_z,
   output logic        rsp_last_cell,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   fsu_pkg::fsu_cfg_type       cfg_ff, cfg_in;
   fsu_pkg::fsu_cell_type      in_item, mem_wdata, mem_rdata;
   fsu_pkg::fsu_entry_type     q_head;
   fsu_pkg::fsu_result_type    out_data;
   logic [fsu_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
   logic                       mem_we, q_empty, q_pop, out_valid, csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_paddr[3:2])
            fsu_pkg::CSR_HALF_DT: cfg_in.half_dt = csr_pwdata[30:0];
            fsu_pkg::CSR_INV_DX:  cfg_in.inv_dx  = csr_pwdata[30:0];
            fsu_pkg::CSR_INV_DY:  cfg_in.inv_dy  = csr_pwdata[30:0];
            default:              cfg_in.inv_dz  = csr_pwdata[30:0];
         endcase
      end
      case (csr_paddr[3:2])
         fsu_pkg::CSR_HALF_DT: csr_prdata = {1'b0, cfg_ff.half_dt};
         fsu_pkg::CSR_INV_DX:  csr_prdata = {1'b0, cfg_ff.inv_dx};
         fsu_pkg::CSR_INV_DY:  csr_prdata = {1'b0, cfg_ff.inv_dy};
         default:              csr_prdata = {1'b0, cfg_ff.inv_dz};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.half_dt <= fsu_pkg::HALF_DT_RESET;
         cfg_ff.inv_dx  <= fsu_pkg::INV_RESET;
         cfg_ff.inv_dy  <= fsu_pkg::INV_RESET;
         cfg_ff.inv_dz  <= fsu_pkg::INV_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign in_item.density  = req_density;
   assign in_item.mom_x    = req_mom_x;
   assign in_item.mom_y    = req_mom_y;
   assign in_item.mom_z    = req_mom_z;
   assign in_item.pressure = req_pressure;

   fsu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .full      (req_full),
      .in_item   (in_item),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop)
   );

   fsu_ram #(
      .WIDTH (fsu_pkg::CELL_W),
      .DEPTH (fsu_pkg::MEM_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   fsu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata),
      .out_valid (out_valid),
      .out_data  (out_data),
      .out_pop   (rsp_pop)
   );

   assign rsp_empty       = !out_valid;
   assign rsp_new_density = out_data.new_density;
   assign rsp_new_mom_x   = out_data.new_mom_x;
   assign rsp_new_mom_y   = out_data.new_mom_y;
   assign rsp_new_mom_z   = out_data.new_mom_z;
   assign rsp_last_cell   = out_data.last_cell;

endmodule

// ----- hdl/fsu_ram.sv -----
// fsu_ram: generic simple dual-port ram, one write and one registered read
// no dependencies
`timescale 1ns / 1ps

module fsu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/fsu_front.sv -----
// fsu_front: grid position tracking, history write and item queue
// depends on fsu_pkg
`timescale 1ns / 1ps

module fsu_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  fsu_pkg::fsu_cell_type      in_item,
   output logic                       mem_we,
   output logic [fsu_pkg::ADDR_W-1:0] mem_waddr,
   output fsu_pkg::fsu_cell_type      mem_wdata,
   output logic                       q_empty,
   output fsu_pkg::fsu_entry_type     q_head,
   input  logic                       q_pop
);

   logic [fsu_pkg::X_W-1:0]    x_ff, x_in;
   logic [fsu_pkg::Y_W-1:0]    y_ff, y_in;
   logic [fsu_pkg::Z_W-1:0]    z_ff, z_in;
   logic [fsu_pkg::ADDR_W-1:0] addr_ff, addr_in;
   fsu_pkg::fsu_entry_type     q_ff [fsu_pkg::QUEUE_DEPTH];
   logic [fsu_pkg::Q_W-1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [fsu_pkg::Q_W:0]      cnt_ff, cnt_in;
   logic                       accept;
   fsu_pkg::fsu_entry_type     entry;

   assign full    = (cnt_ff == (fsu_pkg::Q_W+1)'(fsu_pkg::QUEUE_DEPTH));
   assign q_empty = (cnt_ff == '0);
   assign q_head  = q_ff[rp_ff];
   assign accept  = push && !full;

   assign mem_we    = accept;
   assign mem_waddr = addr_ff;
   assign mem_wdata = in_item;

   always_comb begin
      entry.mom_z    = in_item.mom_z;
      entry.pressure = in_item.pressure;
      entry.addr     = addr_ff;
      // the arriving cell completes the interior cell one plane behind it
      entry.emit = (x_ff >= fsu_pkg::X_W'(1)) && (x_ff <= fsu_pkg::X_W'(fsu_pkg::GRID_X))
                && (y_ff >= fsu_pkg::Y_W'(1)) && (y_ff <= fsu_pkg::Y_W'(fsu_pkg::GRID_Y))
                && (z_ff >= fsu_pkg::Z_W'(2)) && (z_ff <= fsu_pkg::Z_W'(fsu_pkg::GRID_Z + 1));
      entry.last = (x_ff == fsu_pkg::X_W'(fsu_pkg::GRID_X))
                && (y_ff == fsu_pkg::Y_W'(fsu_pkg::GRID_Y))
                && (z_ff == fsu_pkg::Z_W'(fsu_pkg::GRID_Z + 1));

      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      addr_in = addr_ff;
      if (accept) begin
         addr_in = (addr_ff == fsu_pkg::ADDR_W'(fsu_pkg::MEM_DEPTH - 1))
                 ? '0 : addr_ff + fsu_pkg::ADDR_W'(1);
         if (x_ff == fsu_pkg::X_W'(fsu_pkg::PAD_X - 1)) begin
            x_in = '0;
            if (y_ff == fsu_pkg::Y_W'(fsu_pkg::PAD_Y - 1)) begin
               y_in = '0;
               z_in = (z_ff == fsu_pkg::Z_W'(fsu_pkg::PAD_Z - 1))
                    ? '0 : z_ff + fsu_pkg::Z_W'(1);
            end else begin
               y_in = y_ff + fsu_pkg::Y_W'(1);
            end
         end else begin
            x_in = x_ff + fsu_pkg::X_W'(1);
         end
      end

      wp_in  = accept ? wp_ff + fsu_pkg::Q_W'(1) : wp_ff;
      rp_in  = q_pop ? rp_ff + fsu_pkg::Q_W'(1) : rp_ff;
      cnt_in = cnt_ff;
      if (accept && !q_pop) begin
         cnt_in = cnt_ff + (fsu_pkg::Q_W+1)'(1);
      end else if (!accept && q_pop) begin
         cnt_in = cnt_ff - (fsu_pkg::Q_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff    <= '0;
         y_ff    <= '0;
         z_ff    <= '0;
         addr_ff <= '0;
         wp_ff   <= '0;
         rp_ff   <= '0;
         cnt_ff  <= '0;
      end else begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         addr_ff <= addr_in;
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         cnt_ff  <= cnt_in;
      end
      if (accept) begin
         q_ff[wp_ff] <= entry;
      end
   end

endmodule

// ----- hdl/fsu_back.sv -----
// fsu_back: neighbour fetch, shared multiplier sequence and result register
// depends on fsu_pkg
`timescale 1ns / 1ps

module fsu_back (
   input  logic                       clock,
   input  logic                       reset,
   input  fsu_pkg::fsu_cfg_type       cfg,
   input  logic                       q_empty,
   input  fsu_pkg::fsu_entry_type     q_head,
   output logic                       q_pop,
   output logic [fsu_pkg::ADDR_W-1:0] mem_raddr,
   input  fsu_pkg::fsu_cell_type      mem_rdata,
   output logic                       out_valid,
   output fsu_pkg::fsu_result_type    out_data,
   input  logic                       out_pop
);

   fsu_pkg::fsu_back_state_type state_ff, state_in;
   fsu_pkg::fsu_entry_type      cur_ff, cur_in;
   fsu_pkg::fsu_cell_type       nb_ff [6];
   logic [2:0]                  rd_cnt_ff, rd_cnt_in;
   logic [2:0]                  op_ff, op_in;
   logic [fsu_pkg::MAG_W-1:0]   m_ff, m_in;
   logic                        neg_ff, neg_in;
   logic [fsu_pkg::K_W-1:0]     k_ff, k_in;
   logic [fsu_pkg::LO_W-1:0]    plo_ff;
   logic [fsu_pkg::HI_W-1:0]    phi_ff;
   logic [fsu_pkg::R_W-1:0]     mag_ff, mag_in;
   logic signed [fsu_pkg::ACC_W-1:0] acc_ff, acc_in;
   fsu_pkg::fsu_result_type     res_ff, res_in;
   fsu_pkg::fsu_result_type     out_ff;
   logic                        out_valid_ff, out_valid_in;
   logic                        capture;

   logic signed [fsu_pkg::ACC_W-1:0] opnd;
   logic signed [fsu_pkg::ACC_W-1:0] term;
   logic signed [fsu_pkg::ACC_W:0]   upd;
   logic signed [fsu_pkg::ACC_W:0]   base;
   logic [fsu_pkg::ADDR_W:0]         raddr_wide;
   logic [63:0]                      rnd;
   logic [fsu_pkg::R_W-1:0]          sum;

   function automatic logic [31:0] sat32(input logic signed [fsu_pkg::ACC_W:0] v);
      logic [31:0] r;
      if (v > (fsu_pkg::ACC_W+1)'(64'sd2147483647)) begin
         r = 32'h7FFF_FFFF;
      end else if (v < -(fsu_pkg::ACC_W+1)'(64'sd2147483648)) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [fsu_pkg::ACC_W-1:0] sx(input logic [31:0] v);
      return fsu_pkg::ACC_W'($signed(v));
   endfunction

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   // history address of the neighbour being fetched, modulo the ring depth
   always_comb begin
      raddr_wide = {1'b0, cur_ff.addr} - fsu_pkg::nb_age(rd_cnt_ff);
      if (raddr_wide[fsu_pkg::ADDR_W]) begin
         raddr_wide = raddr_wide + (fsu_pkg::ADDR_W+1)'(fsu_pkg::MEM_DEPTH);
      end
      mem_raddr = raddr_wide[fsu_pkg::ADDR_W-1:0];
   end

   always_comb begin
      case (op_ff)
         fsu_pkg::OP_DIV_X: opnd = sx(nb_ff[fsu_pkg::NB_XP].mom_x) - sx(nb_ff[fsu_pkg::NB_XM].mom_x);
         fsu_pkg::OP_DIV_Y: opnd = sx(nb_ff[fsu_pkg::NB_YP].mom_y) - sx(nb_ff[fsu_pkg::NB_YM].mom_y);
         fsu_pkg::OP_DIV_Z: opnd = sx(cur_ff.mom_z) - sx(nb_ff[fsu_pkg::NB_ZM].mom_z);
         fsu_pkg::OP_DEN:   opnd = acc_ff;
         fsu_pkg::OP_MX:    opnd = sx(nb_ff[fsu_pkg::NB_XP].pressure)
                                 - sx(nb_ff[fsu_pkg::NB_XM].pressure);
         fsu_pkg::OP_MY:    opnd = sx(nb_ff[fsu_pkg::NB_YP].pressure)
                                 - sx(nb_ff[fsu_pkg::NB_YM].pressure);
         default:           opnd = sx(cur_ff.pressure) - sx(nb_ff[fsu_pkg::NB_ZM].pressure);
      endcase

      term = neg_ff ? -fsu_pkg::ACC_W'(mag_ff) : fsu_pkg::ACC_W'(mag_ff);
      case (op_ff)
         fsu_pkg::OP_DEN: base = (fsu_pkg::ACC_W+1)'(sx(nb_ff[fsu_pkg::NB_CENTER].density));
         fsu_pkg::OP_MX:  base = (fsu_pkg::ACC_W+1)'(sx(nb_ff[fsu_pkg::NB_CENTER].mom_x));
         fsu_pkg::OP_MY:  base = (fsu_pkg::ACC_W+1)'(sx(nb_ff[fsu_pkg::NB_CENTER].mom_y));
         default:         base = (fsu_pkg::ACC_W+1)'(sx(nb_ff[fsu_pkg::NB_CENTER].mom_z));
      endcase
      upd = base - (fsu_pkg::ACC_W+1)'(term);

      // round to nearest, ties away from zero, then clamp the magnitude
      rnd = 64'(plo_ff) + 64'h8000;
      sum = {phi_ff[33:0], 16'b0} + fsu_pkg::R_W'(rnd[63:16]);
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      rd_cnt_in    = rd_cnt_ff;
      op_in        = op_ff;
      m_in         = m_ff;
      neg_in       = neg_ff;
      k_in         = k_ff;
      mag_in       = mag_ff;
      acc_in       = acc_ff;
      res_in       = res_ff;
      out_valid_in = out_valid_ff && !out_pop;
      q_pop        = 1'b0;
      capture      = 1'b0;

      case (state_ff)
         fsu_pkg::B_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               if (q_head.emit) begin
                  cur_in    = q_head;
                  rd_cnt_in = '0;
                  state_in  = fsu_pkg::B_READ;
               end
            end
         end
         fsu_pkg::B_READ: begin
            capture   = (rd_cnt_ff != '0);
            rd_cnt_in = rd_cnt_ff + 3'd1;
            if (rd_cnt_ff == fsu_pkg::NB_COUNT) begin
               op_in    = fsu_pkg::OP_DIV_X;
               state_in = fsu_pkg::B_SET;
            end
         end
         fsu_pkg::B_SET: begin
            neg_in = opnd[fsu_pkg::ACC_W-1];
            m_in   = opnd[fsu_pkg::ACC_W-1] ? fsu_pkg::MAG_W'(-opnd) : fsu_pkg::MAG_W'(opnd);
            case (op_ff)
               fsu_pkg::OP_DIV_X: k_in = cfg.inv_dx;
               fsu_pkg::OP_DIV_Y: k_in = cfg.inv_dy;
               fsu_pkg::OP_DIV_Z: k_in = cfg.inv_dz;
               default:           k_in = cfg.half_dt;
            endcase
            state_in = fsu_pkg::B_LO;
         end
         fsu_pkg::B_LO: begin
            state_in = fsu_pkg::B_HI;
         end
         fsu_pkg::B_HI: begin
            state_in = fsu_pkg::B_FIN;
         end
         fsu_pkg::B_FIN: begin
            mag_in = (phi_ff >= (fsu_pkg::HI_W'(1) << 34) || sum > fsu_pkg::CLAMP_MAG)
                   ? fsu_pkg::CLAMP_MAG : sum;
            state_in = fsu_pkg::B_ACC;
         end
         fsu_pkg::B_ACC: begin
            case (op_ff)
               fsu_pkg::OP_DIV_X: acc_in = term;
               fsu_pkg::OP_DIV_Y: acc_in = acc_ff + term;
               fsu_pkg::OP_DIV_Z: acc_in = acc_ff + term;
               fsu_pkg::OP_DEN:   res_in.new_density = sat32(upd);
               fsu_pkg::OP_MX:    res_in.new_mom_x = sat32(upd);
               fsu_pkg::OP_MY:    res_in.new_mom_y = sat32(upd);
               default:           res_in.new_mom_z = sat32(upd);
            endcase
            res_in.last_cell = cur_ff.last;
            op_in = op_ff + 3'd1;
            state_in = (op_ff == fsu_pkg::OP_MZ) ? fsu_pkg::B_OUT : fsu_pkg::B_SET;
         end
         fsu_pkg::B_OUT: begin
            if (!out_valid_ff) begin
               out_valid_in = 1'b1;
               state_in     = fsu_pkg::B_IDLE;
            end
         end
         default: begin
            state_in = fsu_pkg::B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fsu_pkg::B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      rd_cnt_ff <= rd_cnt_in;
      op_ff     <= op_in;
      m_ff      <= m_in;
      neg_ff    <= neg_in;
      k_ff      <= k_in;
      mag_ff    <= mag_in;
      acc_ff    <= acc_in;
      res_ff    <= res_in;
      if (capture) begin
         nb_ff[rd_cnt_ff - 3'd1] <= mem_rdata;
      end
      if (state_ff == fsu_pkg::B_LO) begin
         plo_ff <= fsu_pkg::LO_W'(m_ff[31:0] * k_ff);
      end
      if (state_ff == fsu_pkg::B_HI) begin
         phi_ff <= fsu_pkg::HI_W'(m_ff[fsu_pkg::MAG_W-1:32] * k_ff);
      end
      if (state_ff == fsu_pkg::B_OUT && !out_valid_ff) begin
         out_ff <= res_ff;
      end
   end

endmodule

// ----- hdl/fsu_checker.sv -----
// fsu_checker: port-level checks for the stencil update core, bound to the top
// depends on fluid_stencil_update_core
`timescale 1ns / 1ps

module fsu_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [31:0] rsp_new_density,
   input logic        csr_psel,
   input logic        csr_penable,
   input logic        csr_pwrite,
   input logic [3:0]  csr_paddr,
   input logic [31:0] csr_pwdata,
   input logic [31:0] csr_prdata
);

   // reset drops any waiting result
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_new_density))
      else $error("waiting result changed before pop");

   // half_dt reads back its reset value right after reset
   a_cfg_reset: assert property (@(posedge clock)
      $past(reset) && !reset && csr_paddr == {fsu_pkg::CSR_HALF_DT, 2'b00}
      |-> csr_prdata == {1'b0, fsu_pkg::HALF_DT_RESET})
      else $error("half_dt reset value wrong");

   a_cfg_write: assert property (@(posedge clock) disable iff (reset)
      (csr_psel && csr_penable && csr_pwrite && csr_paddr == {fsu_pkg::CSR_HALF_DT, 2'b00})
      ##1 (csr_paddr == {fsu_pkg::CSR_HALF_DT, 2'b00})
      |-> csr_prdata == {1'b0, $past(csr_pwdata[30:0])})
      else $error("half_dt write not seen on read back");

endmodule

bind fluid_stencil_update_core fsu_checker u_fsu_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_new_density (rsp_new_density),
   .csr_psel        (csr_psel),
   .csr_penable     (csr_penable),
   .csr_pwrite      (csr_pwrite),
   .csr_paddr       (csr_paddr),
   .csr_pwdata      (csr_pwdata),
   .csr_prdata      (csr_prdata)
);
